### design/rpct_pkg.sv
// Shared types, constants and a helper function for the RGB pixel colour transform.
// Used by every module of the block; depends on nothing else.
package rpct_pkg;

    // Component and pixel widths
    localparam int COMP_W     = 8;
    localparam int PIX_W      = 3 * COMP_W;
    localparam int BRIGHT_W   = 10;
    localparam int MONO_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [COMP_W-1:0] COMP_MAX = 8'hff;

    // Brightness scale factor: ceil(percent * 2^SCALE_FRAC / 100)
    localparam int SCALE_FRAC = 15;
    localparam int SCALE_W    = 19;
    localparam int PROD_W     = COMP_W + SCALE_W;
    localparam int QUO_W      = PROD_W - SCALE_FRAC;

    // Percent split into percent / 25 and percent % 25
    localparam logic [10:0] DIV25_MUL   = 11'd1311;
    localparam int          DIV25_SHIFT = 15;
    localparam int          DIV25_Q_W   = 6;
    localparam int          DIV25_R_W   = 5;
    localparam logic [9:0]  DIV25       = 10'd25;
    localparam int          FRAC_W      = 13;

    // Grey average by three
    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    // Mono select codes
    localparam logic [MONO_W-1:0] MONO_OFF     = 3'd0;
    localparam logic [MONO_W-1:0] MONO_REFUSED = 3'd7;
    localparam int MONO_BLUE  = 0;
    localparam int MONO_GREEN = 1;
    localparam int MONO_RED   = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INVERT = 2'd0,
        REG_BRIGHT = 2'd1,
        REG_MONO   = 2'd2,
        REG_GREY   = 2'd3
    } cfg_reg_t;

    // Pixel as carried on tdata: blue lowest, red highest
    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } pixel_t;

    // Decoded settings handed to the data path
    typedef struct packed {
        logic               invert;
        logic               bright_en;
        logic [SCALE_W-1:0] scale;
        logic [MONO_W-1:0]  mono;
        logic               two;
        logic               grey;
    } cfg_t;

    // ceil(r * 8192 / 25) for r below 25
    function automatic logic [FRAC_W-1:0] scale_frac(input logic [DIV25_R_W-1:0] r);
        logic [FRAC_W-1:0] f;
        case (r)
            5'd0:    f = 13'd0;
            5'd1:    f = 13'd328;
            5'd2:    f = 13'd656;
            5'd3:    f = 13'd984;
            5'd4:    f = 13'd1311;
            5'd5:    f = 13'd1639;
            5'd6:    f = 13'd1967;
            5'd7:    f = 13'd2294;
            5'd8:    f = 13'd2622;
            5'd9:    f = 13'd2950;
            5'd10:   f = 13'd3277;
            5'd11:   f = 13'd3605;
            5'd12:   f = 13'd3933;
            5'd13:   f = 13'd4260;
            5'd14:   f = 13'd4588;
            5'd15:   f = 13'd4916;
            5'd16:   f = 13'd5243;
            5'd17:   f = 13'd5571;
            5'd18:   f = 13'd5899;
            5'd19:   f = 13'd6226;
            5'd20:   f = 13'd6554;
            5'd21:   f = 13'd6882;
            5'd22:   f = 13'd7209;
            5'd23:   f = 13'd7537;
            5'd24:   f = 13'd7865;
            default: f = 13'd0;
        endcase
        return f;
    endfunction

endpackage

### design/rpct_cfg.sv
// Configuration registers of the pixel colour transform, with the brightness
// scale factor worked out at write time. Depends on rpct_pkg.
module rpct_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rpct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpct_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output rpct_pkg::cfg_t                  cfg
);
    import rpct_pkg::*;

    logic               invert_reg;
    logic               bright_en_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [MONO_W-1:0]  mono_reg;
    logic               two_reg;
    logic               grey_reg;

    logic [20:0]            div25_prod;
    logic [DIV25_Q_W-1:0]   pct_q;
    logic [9:0]             pct_q25;
    logic [9:0]             pct_r_wide;
    logic [SCALE_W-1:0]     scale_next;
    logic [MONO_W-1:0]      mono_wr;
    logic                   two_next;

    // Split percent into 25ths and build ceil(percent * 2^15 / 100)
    always_comb
    begin
        div25_prod = 21'(cfg_wdata) * 21'(DIV25_MUL);
        pct_q      = div25_prod[DIV25_SHIFT +: DIV25_Q_W];
        pct_q25    = 10'({4'd0, pct_q} * DIV25);
        pct_r_wide = cfg_wdata - pct_q25;
        scale_next = {pct_q, {FRAC_W{1'b0}}}
                     + SCALE_W'(scale_frac(pct_r_wide[DIV25_R_W-1:0]));
        mono_wr    = cfg_wdata[MONO_W-1:0];
        two_next   = (mono_wr & (mono_wr - 3'd1)) != MONO_OFF;
    end

    // Register writes; drop a mono write of the refused code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg    <= 1'b0;
            bright_en_reg <= 1'b0;
            scale_reg     <= '0;
            mono_reg      <= MONO_OFF;
            two_reg       <= 1'b0;
            grey_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_INVERT:
                begin
                    invert_reg <= cfg_wdata[0];
                end
                REG_BRIGHT:
                begin
                    bright_en_reg <= cfg_wdata != '0;
                    scale_reg     <= scale_next;
                end
                REG_MONO:
                begin
                    if (mono_wr != MONO_REFUSED)
                    begin
                        mono_reg <= mono_wr;
                        two_reg  <= two_next;
                    end
                end
                REG_GREY:
                begin
                    grey_reg <= cfg_wdata[0];
                end
                default:
                begin
                    invert_reg <= invert_reg;
                end
            endcase
        end
    end

    assign cfg.invert    = invert_reg;
    assign cfg.bright_en = bright_en_reg;
    assign cfg.scale     = scale_reg;
    assign cfg.mono      = mono_reg;
    assign cfg.two       = two_reg;
    assign cfg.grey      = grey_reg;

endmodule

### design/rpct_scale.sv
// Invert and brightness stage: one multiplier per component and a clip at 255,
// closed by a stage register. Depends on rpct_pkg.
module rpct_scale
(
    input  logic             clk,
    input  logic             load,
    input  rpct_pkg::pixel_t pix_in,
    input  rpct_pkg::cfg_t   cfg,
    output rpct_pkg::pixel_t pix_out
);
    import rpct_pkg::*;

    logic [2:0][COMP_W-1:0] comp_in;
    logic [2:0][COMP_W-1:0] inv_c;
    logic [2:0][PROD_W-1:0] prod;
    logic [2:0][QUO_W-1:0]  quo;
    logic [2:0][COMP_W-1:0] comp_next;
    pixel_t                 pix_reg;
    pixel_t                 pix_next;

    assign comp_in = pix_in;

    // Invert, scale by percent / 100 and clip each component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            inv_c[i] = comp_in[i] ^ {COMP_W{cfg.invert}};
            prod[i]  = PROD_W'(inv_c[i]) * PROD_W'(cfg.scale);
            quo[i]   = prod[i][PROD_W-1:SCALE_FRAC];
            if (!cfg.bright_en)
            begin
                comp_next[i] = inv_c[i];
            end
            else if (quo[i] > QUO_W'(COMP_MAX))
            begin
                comp_next[i] = COMP_MAX;
            end
            else
            begin
                comp_next[i] = quo[i][COMP_W-1:0];
            end
        end
        pix_next = comp_next;
    end

    // Hold the stage result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix_out = pix_reg;

endmodule

### design/rpct_mix.sv
// Mono and grey stage: component select, pair average and normalized grey,
// closed by the result register. Depends on rpct_pkg.
module rpct_mix
(
    input  logic             clk,
    input  logic             load,
    input  rpct_pkg::pixel_t pix_in,
    input  rpct_pkg::cfg_t   cfg,
    output rpct_pkg::pixel_t pix_out
);
    import rpct_pkg::*;

    logic [2:0][COMP_W-1:0] comp_in;
    logic [2:0][COMP_W-1:0] kept;
    logic [2:0][COMP_W-1:0] mono_c;
    logic [2:0][COMP_W-1:0] comp_next;
    logic                   mono_on;
    logic [9:0]             kept_sum;
    logic [COMP_W-1:0]      pair_avg;
    logic [9:0]             grey_sum;
    logic [18:0]            div3_prod;
    logic [COMP_W-1:0]      grey_val;
    pixel_t                 pix_reg;
    pixel_t                 pix_next;

    assign comp_in = pix_in;

    always_comb
    begin
        mono_on = cfg.mono != MONO_OFF;

        // Zero the components that mono drops
        for (int i = 0; i < 3; i++)
        begin
            kept[i] = (!mono_on || cfg.mono[i]) ? comp_in[i] : '0;
        end

        // Two kept components both take half their sum
        kept_sum = {2'b00, kept[MONO_BLUE]} + {2'b00, kept[MONO_GREEN]}
                   + {2'b00, kept[MONO_RED]};
        pair_avg = kept_sum[COMP_W:1];
        for (int i = 0; i < 3; i++)
        begin
            if (cfg.two)
            begin
                mono_c[i] = cfg.mono[i] ? pair_avg : '0;
            end
            else
            begin
                mono_c[i] = kept[i];
            end
        end

        // Grey: sum over the components still in play
        grey_sum  = {2'b00, mono_c[MONO_BLUE]} + {2'b00, mono_c[MONO_GREEN]}
                    + {2'b00, mono_c[MONO_RED]};
        div3_prod = 19'(grey_sum) * 19'(DIV3_MUL);
        if (!mono_on)
        begin
            grey_val = div3_prod[DIV3_SHIFT +: COMP_W];
        end
        else if (cfg.two)
        begin
            grey_val = grey_sum[COMP_W:1];
        end
        else
        begin
            grey_val = grey_sum[COMP_W-1:0];
        end

        for (int i = 0; i < 3; i++)
        begin
            comp_next[i] = cfg.grey ? grey_val : mono_c[i];
        end
        pix_next = comp_next;
    end

    // Hold the result beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix_out = pix_reg;

endmodule

### design/rgb_pixel_colour_transform.sv
// Top level of the RGB pixel colour transform: input register, the two work
// stages and the beat flow control. Depends on rpct_pkg, rpct_cfg, rpct_scale, rpct_mix.
//
// The block takes one 24-bit pixel per clock and returns each transformed pixel
// through three registers (input register, scale register, result register). Its
// throughput is one pixel every cycle while the output side takes beats; the
// three stage registers advance independently, so a bubble is filled as soon
// as the stage ahead is free and up to three pixels are in flight. Invert,
// brightness (percent, clipped at 255), mono select and grey run in that
// order. Settings written on the configuration port take effect on the next
// cycle and apply to pixels accepted after the write; write them only while no
// pixel is in flight. A mono write of seven is ignored.
module rgb_pixel_colour_transform
(
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rpct_pkg::PIX_W-1:0]      s_axis_tdata,   // blue_in, green_in, red_in
    // master side
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rpct_pkg::PIX_W-1:0]      m_axis_tdata,   // blue_out, green_out, red_out
    // configuration write port
    input  logic                            cfg_we,
    input  logic [rpct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpct_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rpct_pkg::*;

    cfg_t   cfg;
    pixel_t pix_in_reg;
    pixel_t pix_scaled;
    pixel_t pix_result;
    logic   in_valid_reg;
    logic   mid_valid_reg;
    logic   out_valid_reg;
    logic   in_ready;
    logic   mid_ready;
    logic   out_ready;

    // Stage moves when it is empty or the stage ahead moves
    assign out_ready = !out_valid_reg || m_axis_tready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || mid_ready;

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = pix_result;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (mid_ready)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    // Capture the incoming beat
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && in_ready)
        begin
            pix_in_reg <= s_axis_tdata;
        end
    end

    rpct_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rpct_scale u_scale
    (
        .clk     (clk),
        .load    (in_valid_reg && mid_ready),
        .pix_in  (pix_in_reg),
        .cfg     (cfg),
        .pix_out (pix_scaled)
    );

    rpct_mix u_mix
    (
        .clk     (clk),
        .load    (mid_valid_reg && out_ready),
        .pix_in  (pix_scaled),
        .cfg     (cfg),
        .pix_out (pix_result)
    );

endmodule

### design/rpct_checker.sv
// Port-level checks for the RGB pixel colour transform, bound to the top level.
// Depends on rpct_pkg for widths.
module rpct_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [rpct_pkg::PIX_W-1:0] m_axis_tdata
);
    import rpct_pkg::*;

    logic       in_beat;
    logic       out_beat;
    logic [2:0] pend_reg;
    logic [2:0] pend_next;

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign out_beat  = m_axis_tvalid && m_axis_tready;
    assign pend_next = 3'(pend_reg + {2'b00, in_beat} - {2'b00, out_beat});

    // Track pixels accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A stalled result stays offered with the same data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat withdrawn or changed under stall");

    // No result without a pixel in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pend_reg != 3'd0)
        else $error("result beat with no pixel in flight");

    // Never more pixels in flight than stage registers
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd3)
        else $error("more than three pixels in flight");

    // An accepted pixel reaches the output through the input, scale and result registers when nothing stalls
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_beat, 3) && $past(m_axis_tready, 2) && $past(m_axis_tready, 1)
        && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)
        |-> m_axis_tvalid)
        else $error("pixel not delivered after three free cycles");

endmodule

bind rgb_pixel_colour_transform rpct_checker u_rpct_checker (.*);

### verif/tb_rgb_pixel_colour_transform.sv
// Self-checking testbench for rgb_pixel_colour_transform: random pixel streams
// under several register settings, checked beat by beat by a scoreboard class.
// Depends on rpct_pkg and the block's top level only.
module tb_rgb_pixel_colour_transform;
    import rpct_pkg::*;

    localparam int PERCENT_DIV  = 100;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_PIXELS  = 140;

    // Predicts the transformed pixel for every accepted input beat and
    // checks the output beats against those predictions in order.
    class pixel_scoreboard;
        logic                invert = 1'b0;
        logic [BRIGHT_W-1:0] bright = '0;
        logic [MONO_W-1:0]   mono   = MONO_OFF;
        logic                grey   = 1'b0;
        pixel_t              expected_q[$];
        int                  errors = 0;

        // Mirror a register write, with the block's masking and refusal rules
        function void note_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_INVERT: invert = data[0];
                REG_BRIGHT: bright = data[BRIGHT_W-1:0];
                REG_MONO:   if (data[MONO_W-1:0] != MONO_REFUSED) mono = data[MONO_W-1:0];
                REG_GREY:   grey = data[0];
                default:    ;
            endcase
        endfunction

        function int unsigned scale_clip(int unsigned c);
            int unsigned v;
            v = (c * bright) / PERCENT_DIV;
            return (v > COMP_MAX) ? COMP_MAX : v;
        endfunction

        // Invert, brightness, mono and grey in that order
        function pixel_t transform(pixel_t p);
            int unsigned b, g, r, avg, sum, div;
            bit          two;
            pixel_t      res;
            b = p.blue;
            g = p.green;
            r = p.red;
            two = (mono & (mono - 1'b1)) != '0;
            if (invert)
            begin
                b = b ^ COMP_MAX;
                g = g ^ COMP_MAX;
                r = r ^ COMP_MAX;
            end
            if (bright != '0)
            begin
                b = scale_clip(b);
                g = scale_clip(g);
                r = scale_clip(r);
            end
            if (mono != MONO_OFF)
            begin
                if (!mono[MONO_BLUE])  b = 0;
                if (!mono[MONO_GREEN]) g = 0;
                if (!mono[MONO_RED])   r = 0;
                if (two)
                begin
                    avg = (b + g + r) / 2;
                    b = mono[MONO_BLUE]  ? avg : 0;
                    g = mono[MONO_GREEN] ? avg : 0;
                    r = mono[MONO_RED]   ? avg : 0;
                end
            end
            if (grey)
            begin
                sum = b + g + r;
                div = (mono == MONO_OFF) ? 3 : (two ? 2 : 1);
                b = (sum / div) & COMP_MAX;
                g = b;
                r = b;
            end
            res.blue  = b[COMP_W-1:0];
            res.green = g[COMP_W-1:0];
            res.red   = r[COMP_W-1:0];
            return res;
        endfunction

        function void note_pixel(pixel_t p);
            expected_q.push_back(transform(p));
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (expected_q.size() == 0)
            begin
                $error("output beat %h with no pixel outstanding", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.blue !== want.blue)
            begin
                $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
                errors++;
            end
            if (got.green !== want.green)
            begin
                $error("green_out: expected %0d, got %0d", want.green, got.green);
                errors++;
            end
            if (got.red !== want.red)
            begin
                $error("red_out: expected %0d, got %0d", want.red, got.red);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata  = '0;     // blue_in, green_in, red_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PIX_W-1:0]      m_axis_tdata;           // blue_out, green_out, red_out
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = REG_INVERT;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    pixel_scoreboard sb;
    bit              src_idle  = 1'b0;
    bit              sink_idle = 1'b0;

    rgb_pixel_colour_transform dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap(bit enable);
        int roll;
        if (!enable) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Component with a bias toward the extremes
    function automatic logic [COMP_W-1:0] pick_comp();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COMP_MAX;
            default: return COMP_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Flag or mono value: often small, sometimes with upper bits set
    function automatic logic [CFG_DATA_W-1:0] pick_setting();
        if ($urandom_range(0, 1)) return CFG_DATA_W'($urandom_range(0, 7));
        return CFG_DATA_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_bright();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 10'd1023;
            2:       return 10'd100;
            3:       return CFG_DATA_W'($urandom_range(99, 101));
            4:       return CFG_DATA_W'($urandom_range(0, 1023));
            default: return CFG_DATA_W'($urandom_range(1, 200));
        endcase
    endfunction

    // Output side: accept beats, stall at random when enabled
    initial
    begin
        int run_len;
        int stall;
        forever
        begin
            run_len = sink_idle ? $urandom_range(1, 12) : 16;
            m_axis_tready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall = pick_gap(sink_idle);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Check every output beat
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(pixel_t'(m_axis_tdata));
    end

    // Present one pixel, hold it until accepted, then predict its result
    task automatic send_pixel(input pixel_t p);
        int gap;
        gap = pick_gap(src_idle);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_pixel(p);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.note_write(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] inv,
                                  input logic [CFG_DATA_W-1:0] bright,
                                  input logic [CFG_DATA_W-1:0] mono,
                                  input logic [CFG_DATA_W-1:0] grey);
        write_reg(REG_INVERT, inv);
        write_reg(REG_BRIGHT, bright);
        write_reg(REG_MONO, mono);
        write_reg(REG_GREY, grey);
    endtask

    // Drop valid and wait until every predicted pixel has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Run limit
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        pixel_t px;
        sb = new;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: black, white and one random pixel per setting
        for (int c = 0; c < 8; c++)
        begin
            src_idle  = (c >= 4);
            sink_idle = (c % 2 == 1);
            case (c)
                1: apply_settings(10'd1, 10'd0, 10'd0, 10'd0);
                2: apply_settings(10'd0, 10'd1023, 10'd0, 10'd0);
                3: apply_settings(10'd1, 10'd1, 10'd0, 10'd0);
                4: apply_settings(10'd0, 10'd0, 10'd1, 10'd1);
                5: apply_settings(10'd0, 10'd0, 10'd6, 10'd1);
                6:
                begin
                    // mono seven is refused, mono stays at red and blue
                    apply_settings(10'd0, 10'd150, 10'd5, 10'd0);
                    write_reg(REG_MONO, CFG_DATA_W'(MONO_REFUSED));
                end
                7: apply_settings(10'h3fe, 10'd100, 10'h3f8, 10'h3ff);
                default: ;
            endcase
            send_pixel('0);
            send_pixel('1);
            px = pixel_t'($urandom);
            send_pixel(px);
            drain();
        end

        // Random phases, each under its own setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            src_idle  = (ph % 3 != 0);
            sink_idle = (ph % 4 != 1);
            if (ph == 0)
                apply_settings(10'h3ff, 10'h3ff, 10'd6, 10'h3ff);
            else if (ph == RANDOM_PHASES - 1)
                apply_settings(10'd1, 10'd1, 10'd4, 10'd0);
            else
                apply_settings(pick_setting(), pick_bright(), pick_setting(), pick_setting());
            repeat (PHASE_PIXELS)
            begin
                px.blue  = pick_comp();
                px.green = pick_comp();
                px.red   = pick_comp();
                send_pixel(px);
            end
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
